// ===== hw/rtl/rgbhsv_pkg.sv =====
// Shared widths and scale constants for the RGB to HSV pixel converter.
// No dependencies; the converter and its checker import it.
package rgbhsv_pkg;

  // Channel and result field widths.
  localparam int CH_W  = 8;
  localparam int OUT_W = 7;

  // Percentage scale and the full-scale channel code.
  localparam int PCT        = 100;
  localparam int FULL_SCALE = 255;

  // Datapath widths: delta*100 and max*100 fit in 15 bits, the hue numerator
  // and denominator (6*delta) in 11 bits, and the hue numerator times 100 in 18.
  localparam int PROD_W     = 15;
  localparam int HUE_NUM_W  = 11;
  localparam int HUE_PROD_W = 18;

  // Front-end stages ahead of the dividers; one divider stage per quotient bit.
  localparam int FRONT_STAGES = 3;
  localparam int PIPE_LAT     = FRONT_STAGES + OUT_W;

endpackage

// ===== hw/rtl/rgbhsv_divider.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Stand-alone; the converter instantiates it for hue and saturation.
module rgbhsv_divider #(
  parameter int DIVIDEND_W = 15,
  parameter int DIVISOR_W  = 8,
  parameter int Q_W        = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  out_valid,
  output logic [Q_W-1:0]        quotient
);

  // The caller guarantees the quotient fits in Q_W bits. A zero divisor
  // gives a zero quotient.
  localparam int W = (DIVIDEND_W > DIVISOR_W + Q_W) ? DIVIDEND_W : DIVISOR_W + Q_W;

  logic [W-1:0]         rem_s [Q_W];
  logic [DIVISOR_W-1:0] dvs_s [Q_W];
  logic [Q_W-1:0]       quo_s [Q_W+1];
  logic                 vld_s [Q_W+1];

  assign rem_s[0] = W'(dividend);
  assign dvs_s[0] = divisor;
  assign quo_s[0] = '0;
  assign vld_s[0] = in_valid;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int Shift = Q_W - 1 - i;
    logic [W-1:0] trial;
    logic         fits;

    assign trial = W'(dvs_s[i]) << Shift;
    assign fits  = (dvs_s[i] != '0) && (rem_s[i] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i+1] <= 1'b0;
      end else begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      quo_s[i+1] <= {quo_s[i][Q_W-2:0], fits};
    end

    if (i < Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_s[i+1] <= fits ? rem_s[i] - trial : rem_s[i];
        dvs_s[i+1] <= dvs_s[i];
      end
    end
  end

  assign out_valid = vld_s[Q_W];
  assign quotient  = quo_s[Q_W];

endmodule

// ===== hw/rtl/rgb_to_hsv_pixel.sv =====
// Top level of the RGB to HSV pixel converter.
// Depends on rgbhsv_pkg and rgbhsv_divider.
//
// One pixel beat of three 8-bit channels is taken on every clock at which
// start is high, and its hue, saturation and value leave with done high for
// a single cycle. The pipeline is fully streamed: three front-end stages find
// max, min and the hue sector and form the dividends, then two 7-stage
// restoring dividers, one quotient bit per stage, produce hue and saturation
// in parallel. Value is a division by the constant 255, done with a
// reciprocal multiply and carried through a 7-stage delay line so it leaves
// with the other two. The front-end and divider depth set the latency; the
// rate is one pixel per clock. busy is always low, and because the receiver
// cannot stall, results must be captured in the cycle that done is high. Gray
// and black pixels give hue 0 and saturation 0; value is computed as usual.
module rgb_to_hsv_pixel (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rgbhsv_pkg::CH_W-1:0]   blue,
  input  logic [rgbhsv_pkg::CH_W-1:0]   green,
  input  logic [rgbhsv_pkg::CH_W-1:0]   red,
  output logic                          done,
  output logic [rgbhsv_pkg::OUT_W-1:0]  hue,
  output logic [rgbhsv_pkg::OUT_W-1:0]  saturation,
  output logic [rgbhsv_pkg::OUT_W-1:0]  value
);

  import rgbhsv_pkg::*;

  // For a dividend n up to 25500, floor(n/255) equals ((n+1)*257) >> 16.
  localparam int VAL_RECIP  = 257;
  localparam int VAL_SHIFT  = 16;
  localparam int VAL_PROD_W = VAL_SHIFT + OUT_W;

  // Which channel holds the maximum; red wins ties, then green.
  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_t;

  assign busy = 1'b0;

  // Stage 1: maximum, delta, sector and the signed channel difference.
  logic [CH_W-1:0] mx_c, mn_c, bg_max, bg_min;
  sector_t         sec_c;
  logic [CH_W:0]   diff_c;

  always_comb begin
    bg_max = (blue > green) ? blue : green;
    bg_min = (blue < green) ? blue : green;
    mx_c   = (red > bg_max) ? red : bg_max;
    mn_c   = (red < bg_min) ? red : bg_min;
    if (red >= mx_c) begin
      sec_c  = SECTOR_RED;
      diff_c = {1'b0, green} - {1'b0, blue};
    end else if (green >= mx_c) begin
      sec_c  = SECTOR_GREEN;
      diff_c = {1'b0, blue} - {1'b0, red};
    end else begin
      sec_c  = SECTOR_BLUE;
      diff_c = {1'b0, red} - {1'b0, green};
    end
  end

  logic            v1;
  logic [CH_W-1:0] mx1, dl1;
  sector_t         sec1;
  logic [CH_W:0]   diff1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    mx1   <= mx_c;
    dl1   <= mx_c - mn_c;
    sec1  <= sec_c;
    diff1 <= diff_c;
  end

  // Stage 2: hue numerator wrapped into 0 .. 6*delta-1, and the 6*delta
  // denominator; the saturation and value dividends are scaled by 100.
  logic [HUE_NUM_W-1:0] base_c, den_c;
  logic [HUE_NUM_W:0]   num_c;

  always_comb begin
    unique case (sec1)
      SECTOR_RED:   base_c = '0;
      SECTOR_GREEN: base_c = HUE_NUM_W'(dl1) << 1;
      SECTOR_BLUE:  base_c = HUE_NUM_W'(dl1) << 2;
      default:      base_c = '0;
    endcase
    den_c = (HUE_NUM_W'(dl1) << 2) + (HUE_NUM_W'(dl1) << 1);
    num_c = {1'b0, base_c} + {{(HUE_NUM_W - CH_W){diff1[CH_W]}}, diff1};
    // Only the red sector can go negative; one turn brings it back.
    if (num_c[HUE_NUM_W]) begin
      num_c = num_c + {1'b0, den_c};
    end
  end

  logic                 v2;
  logic [HUE_NUM_W-1:0] num2, den2;
  logic [PROD_W-1:0]    satn2, valn2;
  logic [CH_W-1:0]      mx2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    num2  <= num_c[HUE_NUM_W-1:0];
    den2  <= den_c;
    satn2 <= PROD_W'(dl1) * PROD_W'(PCT);
    valn2 <= PROD_W'(mx1) * PROD_W'(PCT);
    mx2   <= mx1;
  end

  // Stage 3: scale the hue numerator by 100 so all three results start
  // together.
  logic                  v3;
  logic [HUE_PROD_W-1:0] huen3;
  logic [HUE_NUM_W-1:0]  den3;
  logic [PROD_W-1:0]     satn3, valn3;
  logic [CH_W-1:0]       mx3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    huen3 <= HUE_PROD_W'(num2) * HUE_PROD_W'(PCT);
    den3  <= den2;
    satn3 <= satn2;
    valn3 <= valn2;
    mx3   <= mx2;
  end

  // Dividers. A gray pixel has a zero hue denominator, which the divider
  // turns into hue 0; its saturation dividend is zero as well.
  logic hue_vld, sat_vld;

  rgbhsv_divider #(
    .DIVIDEND_W (HUE_PROD_W),
    .DIVISOR_W  (HUE_NUM_W),
    .Q_W        (OUT_W)
  ) u_hue_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .dividend  (huen3),
    .divisor   (den3),
    .out_valid (hue_vld),
    .quotient  (hue)
  );

  rgbhsv_divider #(
    .DIVIDEND_W (PROD_W),
    .DIVISOR_W  (CH_W),
    .Q_W        (OUT_W)
  ) u_sat_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .dividend  (satn3),
    .divisor   (mx3),
    .out_valid (sat_vld),
    .quotient  (saturation)
  );

  // Value: max*100 over 255 by reciprocal multiply, then one register per
  // divider stage so it lines up with hue and saturation.
  logic [VAL_PROD_W-1:0] val_prod_c;
  logic [OUT_W-1:0]      val_d [OUT_W];

  assign val_prod_c = (VAL_PROD_W'(valn3) + VAL_PROD_W'(1)) * VAL_PROD_W'(VAL_RECIP);

  always_ff @(posedge clk) begin
    val_d[0] <= val_prod_c[VAL_SHIFT +: OUT_W];
    for (int k = 1; k < OUT_W; k++) begin
      val_d[k] <= val_d[k-1];
    end
  end

  assign value = val_d[OUT_W-1];

  // The two valid lines run in lockstep.
  assign done = hue_vld && sat_vld;

endmodule

// ===== hw/rtl/rgbhsv_checker.sv =====
// Port-level assertions for the RGB to HSV pixel converter, bound to its top.
// Depends on rgbhsv_pkg and on the rgb_to_hsv_pixel port list.
module rgbhsv_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [rgbhsv_pkg::CH_W-1:0]   blue,
  input logic [rgbhsv_pkg::CH_W-1:0]   green,
  input logic [rgbhsv_pkg::CH_W-1:0]   red,
  input logic                          done,
  input logic [rgbhsv_pkg::OUT_W-1:0]  hue,
  input logic [rgbhsv_pkg::OUT_W-1:0]  saturation,
  input logic [rgbhsv_pkg::OUT_W-1:0]  value
);

  import rgbhsv_pkg::*;

  // Every accepted beat comes out after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("accepted pixel did not produce a result on time");

  // No result appears without a beat accepted at the matching cycle.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##PIPE_LAT !done)
    else $error("result strobe without a matching pixel");

  // Results stay within their percentage ranges.
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hue <= OUT_W'(99)) && (saturation <= OUT_W'(PCT)) && (value <= OUT_W'(PCT)))
    else $error("result out of range");

  // A gray pixel gives zero hue and zero saturation.
  a_gray: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && (red == green) && (green == blue), PIPE_LAT))
      |-> (hue == '0) && (saturation == '0))
    else $error("gray pixel gave nonzero hue or saturation");

  // A full-scale red channel gives full value.
  a_full_red: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && (red == CH_W'(FULL_SCALE)), PIPE_LAT)) |-> (value == OUT_W'(PCT)))
    else $error("full-scale pixel did not give full value");

endmodule

bind rgb_to_hsv_pixel rgbhsv_checker u_checker (.*);
